/* rtl/core/stk_pkg.sv */
// Shared widths, defaults and the stored-entry type for the sorted top-k table.
// No dependencies; compiled first.
`default_nettype none

package stk_pkg;

    localparam int TableSizeDef = 10;

    localparam int KeyW    = 17;
    localparam int NameW   = 32;
    localparam int YearW   = 16;
    localparam int MonthW  = 4;
    localparam int DayW    = 5;
    localparam int HourW   = 5;
    localparam int MinuteW = 6;
    localparam int SecondW = 6;
    localparam int RankW   = 4;
    localparam int CountW  = 4;

    // one table slot; the stamp part packs to 42 bits, year on top
    typedef struct packed {
        logic [KeyW-1:0]    key;
        logic [NameW-1:0]   name;
        logic [YearW-1:0]   year;
        logic [MonthW-1:0]  month;
        logic [DayW-1:0]    day;
        logic [HourW-1:0]   hour;
        logic [MinuteW-1:0] minute;
        logic [SecondW-1:0] second;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/core/stk_ifs.sv */
// Valid/ready channel interfaces for the sorted top-k table: entry in, result out.
// Depends on stk_pkg.
`default_nettype none

interface stk_in_if;
    logic                        valid;
    logic                        ready;
    logic [stk_pkg::KeyW-1:0]    elapsed_time;
    logic [stk_pkg::NameW-1:0]   name_id;
    logic [stk_pkg::YearW-1:0]   stamp_year;
    logic [stk_pkg::MonthW-1:0]  stamp_month;
    logic [stk_pkg::DayW-1:0]    stamp_day;
    logic [stk_pkg::HourW-1:0]   stamp_hour;
    logic [stk_pkg::MinuteW-1:0] stamp_minute;
    logic [stk_pkg::SecondW-1:0] stamp_second;

    modport source (
        output valid, elapsed_time, name_id, stamp_year, stamp_month,
               stamp_day, stamp_hour, stamp_minute, stamp_second,
        input  ready
    );
    modport sink (
        input  valid, elapsed_time, name_id, stamp_year, stamp_month,
               stamp_day, stamp_hour, stamp_minute, stamp_second,
        output ready
    );
endinterface

interface stk_out_if;
    logic                       valid;
    logic                       ready;
    logic [stk_pkg::RankW-1:0]  landing_rank;
    logic                       kept;
    logic [stk_pkg::CountW-1:0] entry_count;

    modport source (
        output valid, landing_rank, kept, entry_count,
        input  ready
    );
    modport sink (
        input  valid, landing_rank, kept, entry_count,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/core/sorted_top_k_insert_table.sv */
// Top level of the sorted top-k table: input register, parallel compare and
// shift of all slots, result register. Depends on stk_pkg and stk_ifs.
`default_nettype none

//  channel   dir  handshake     carries
//  i_item    in   valid/ready   elapsed_time, name_id, stamp_* (one new entry)
//  o_result  out  valid/ready   landing_rank, kept, entry_count
//
//  Entry register, then compare/shift into the result register.
//  One item per cycle sustained while the result is taken; every slot compares
//  against the new key at once and the whole table shifts in that same cycle.
//  Sync active-low reset clears the entry count and both valid flags only.
//  A stalled result holds the entry register; i_item.ready drops only then.
module sorted_top_k_insert_table #(
    parameter int TABLE_SIZE = stk_pkg::TableSizeDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    stk_in_if.sink      i_item,
    stk_out_if.source   o_result
);

    localparam int CntW = $clog2(TABLE_SIZE + 1);

    // entry register
    logic            r_in_valid;
    stk_pkg::t_entry r_in;

    // table: slots below r_count hold sorted entries
    stk_pkg::t_entry r_slot [TABLE_SIZE];
    stk_pkg::t_entry n_slot [TABLE_SIZE];
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;

    // result register (rank kept full width for checks)
    logic            r_out_valid;
    logic [CntW-1:0] r_rank;
    logic            r_kept;
    logic [CntW-1:0] r_res_count;

    logic [TABLE_SIZE-1:0] le;       // slot valid and key <= new key
    logic [CntW-1:0]       n_rank;
    logic                  advance;  // entry register moves into result register

    assign advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    // compare: table is sorted, so le is a thermometer and its popcount is the slot
    always_comb begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            le[i] = (CntW'(i) < r_count) && (r_slot[i].key <= r_in.key);
        end
        n_rank = CntW'($countones(le));
    end

    // shift: slots above the landing point keep, the landing slot takes the new
    // entry, the rest take their upper neighbor; the last one falls off
    always_comb begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (le[i]) begin
                n_slot[i] = r_slot[i];
            end else if (i == 0) begin
                n_slot[i] = r_in;
            end else if (le[(i > 0) ? i - 1 : 0]) begin
                n_slot[i] = r_in;
            end else begin
                n_slot[i] = r_slot[(i > 0) ? i - 1 : 0];
            end
        end
        n_count = (r_count == CntW'(TABLE_SIZE)) ? r_count : r_count + 1'b1;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.key    <= i_item.elapsed_time;
            r_in.name   <= i_item.name_id;
            r_in.year   <= i_item.stamp_year;
            r_in.month  <= i_item.stamp_month;
            r_in.day    <= i_item.stamp_day;
            r_in.hour   <= i_item.stamp_hour;
            r_in.minute <= i_item.stamp_minute;
            r_in.second <= i_item.stamp_second;
        end
        if (advance) begin
            r_slot      <= n_slot;
            r_rank      <= n_rank;
            r_kept      <= (n_rank != CntW'(TABLE_SIZE));
            r_res_count <= n_count;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.landing_rank = stk_pkg::RankW'(r_rank);
    assign o_result.kept         = r_kept;
    assign o_result.entry_count  = stk_pkg::CountW'(r_res_count);

    // ---- checks ----
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(TABLE_SIZE))
        else $error("entry count above table size");

    a_kept_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kept == (r_rank < CntW'(TABLE_SIZE))))
        else $error("kept flag disagrees with landing rank");

    a_rank_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rank <= r_res_count))
        else $error("landing rank beyond entry count");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_count == (($past(r_count) == CntW'(TABLE_SIZE)) ?
                                 CntW'(TABLE_SIZE) : $past(r_count) + 1'b1)))
        else $error("entry count did not step on insert");

    for (genvar g = 1; g < TABLE_SIZE; g++) begin : g_order
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (CntW'(g) < r_count) |-> (r_slot[g-1].key <= r_slot[g].key))
            else $error("table out of key order");
    end

endmodule

`default_nettype wire

/* sim/tb_sorted_top_k_insert_table.sv */
`timescale 1ns / 100ps
// Self-checking testbench for sorted_top_k_insert_table: drives new entries,
// predicts landing rank, kept flag and count, and checks every result item.
// Depends on stk_pkg, stk_ifs and the table RTL.

module tb_sorted_top_k_insert_table;

    localparam int    TABLE_SIZE = stk_pkg::TableSizeDef;
    localparam int    CLK_PERIOD = 4;
    localparam int    RESET_CYCLES = 7;
    localparam int    RANDOM_ITEMS = 650;
    localparam int    LONG_HOLD = 80;          // receiver hold-off to back up the pipe
    localparam int    DRAIN_CYCLES = 8;
    localparam int    KEY_MAX = (1 << stk_pkg::KeyW) - 1;

    typedef struct packed {
        logic [stk_pkg::RankW-1:0]  landing_rank;
        logic                       kept;
        logic [stk_pkg::CountW-1:0] entry_count;
    } t_insert_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    stk_in_if  entry_ch ();
    stk_out_if result_ch ();

    sorted_top_k_insert_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (entry_ch),
        .o_result (result_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Predictor: own copy of the ranked table, best (smallest key) first
    // ---------------------------------------------------------------
    stk_pkg::t_entry ranked_table [TABLE_SIZE];
    int unsigned     stored_count = 0;
    t_insert_outcome expected_outcomes [$];

    stk_pkg::t_entry pending_entries [$];
    stk_pkg::t_entry offered_entry;
    int unsigned     entry_total = 0;
    int unsigned     n_accepted = 0;
    int unsigned     n_checked = 0;
    int unsigned     n_errors = 0;
    int unsigned     send_gap = 0;
    int unsigned     recv_hold = 0;

    // Landing slot is the number of stored keys <= new key, so equal keys
    // keep arrival order. A full table drops whatever falls past the end.
    function automatic void rank_new_entry(input stk_pkg::t_entry e);
        int unsigned     slot;
        int unsigned     last;
        t_insert_outcome outcome;
        slot = 0;
        for (int i = 0; i < stored_count; i++) begin
            if (ranked_table[i].key <= e.key)
                slot++;
        end
        if (slot < TABLE_SIZE) begin
            last = (stored_count < TABLE_SIZE) ? stored_count : TABLE_SIZE - 1;
            for (int i = last; i > slot; i--)
                ranked_table[i] = ranked_table[i - 1];
            ranked_table[slot] = e;
        end
        if (stored_count < TABLE_SIZE)
            stored_count++;
        outcome.landing_rank = slot[stk_pkg::RankW-1:0];
        outcome.kept         = (slot < TABLE_SIZE);
        outcome.entry_count  = stored_count[stk_pkg::CountW-1:0];
        expected_outcomes.push_back(outcome);
    endfunction

    // Stamp fields span their full width; out-of-calendar values are legal.
    function automatic stk_pkg::t_entry random_entry(input int unsigned key);
        stk_pkg::t_entry e;
        e.key    = key[stk_pkg::KeyW-1:0];
        e.name   = $urandom();
        e.year   = $urandom_range(0, (1 << stk_pkg::YearW) - 1);
        e.month  = $urandom_range(0, (1 << stk_pkg::MonthW) - 1);
        e.day    = $urandom_range(0, (1 << stk_pkg::DayW) - 1);
        e.hour   = $urandom_range(0, (1 << stk_pkg::HourW) - 1);
        e.minute = $urandom_range(0, (1 << stk_pkg::MinuteW) - 1);
        e.second = $urandom_range(0, (1 << stk_pkg::SecondW) - 1);
        return e;
    endfunction

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            n_errors++;
        end
    endfunction

    // ---------------------------------------------------------------
    // Entry driver: offers queued items, idles for a random gap after each,
    // with idle-free stretches; predicts on every accepted item.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entry_ch.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (entry_ch.valid && entry_ch.ready) begin
                rank_new_entry(offered_entry);
                n_accepted++;
            end
            if (!entry_ch.valid || entry_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    entry_ch.valid <= 1'b0;
                end else if (pending_entries.size() > 0) begin
                    offered_entry = pending_entries.pop_front();
                    entry_ch.valid        <= 1'b1;
                    entry_ch.elapsed_time <= offered_entry.key;
                    entry_ch.name_id      <= offered_entry.name;
                    entry_ch.stamp_year   <= offered_entry.year;
                    entry_ch.stamp_month  <= offered_entry.month;
                    entry_ch.stamp_day    <= offered_entry.day;
                    entry_ch.stamp_hour   <= offered_entry.hour;
                    entry_ch.stamp_minute <= offered_entry.minute;
                    entry_ch.stamp_second <= offered_entry.second;
                    send_gap = ((n_accepted % 100) < 30) ? 0 : $urandom_range(0, 5);
                end else begin
                    entry_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: checks each result item against the oldest
    // prediction, then holds ready low for a random hold-off. Once, a long
    // hold-off lets the sender fill the pipe so the input stalls.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_insert_outcome want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, actual rank %0d kept %0d count %0d",
                             $time, result_ch.landing_rank, result_ch.kept,
                             result_ch.entry_count);
                    n_errors++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("landing_rank", want.landing_rank, result_ch.landing_rank);
                    check_field("kept", want.kept, result_ch.kept);
                    check_field("entry_count", want.entry_count, result_ch.entry_count);
                end
                n_checked++;
                if (n_checked == 300)
                    recv_hold = LONG_HOLD;
                else
                    recv_hold = ((n_checked % 120) < 40) ? 0 : $urandom_range(0, 5);
            end else if (recv_hold > 0) begin
                recv_hold--;
            end
            result_ch.ready <= (recv_hold == 0);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    // Directed keys: empty-table insert, both key extremes, ties, fill to
    // full, drop at full (key equal to the last), land inside when full,
    // land in the last slot, tie inside a full table.
    int unsigned directed_keys [16] = '{
        120000, KEY_MAX, 120000, 0,
        121000, 122000, 123000, 124000, 125000, 126000,
        KEY_MAX, 110000, 126000, 125999, 120000, KEY_MAX
    };

    initial begin
        stk_pkg::t_entry e;
        int unsigned     drift_base;
        int unsigned     roll;
        int unsigned     new_key;
        int unsigned     recent_keys [$];

        entry_ch.valid        = 1'b0;
        entry_ch.elapsed_time = '0;
        entry_ch.name_id      = '0;
        entry_ch.stamp_year   = '0;
        entry_ch.stamp_month  = '0;
        entry_ch.stamp_day    = '0;
        entry_ch.stamp_hour   = '0;
        entry_ch.stamp_minute = '0;
        entry_ch.stamp_second = '0;
        result_ch.ready       = 1'b0;

        foreach (directed_keys[i]) begin
            if (i == 0) begin
                e = '0;                          // every stamp field at zero
                e.key = directed_keys[i];
            end else if (i == 1) begin
                e = '1;                          // every field all ones
            end else begin
                e = random_entry(directed_keys[i]);
            end
            pending_entries.push_back(e);
        end

        // Keys drift downward so new entries keep landing at varied ranks
        // in a full table; some ties with recent keys, some sure drops.
        drift_base = 119000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 70 || recent_keys.size() == 0) begin
                new_key = drift_base - $urandom_range(0, 3000);
                if (drift_base > 5000)
                    drift_base -= $urandom_range(0, 300);
            end else if (roll < 82) begin
                new_key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
            end else if (roll < 94) begin
                new_key = $urandom_range(drift_base, KEY_MAX);
            end else begin
                new_key = KEY_MAX;
            end
            recent_keys.push_back(new_key);
            if (recent_keys.size() > 12)
                void'(recent_keys.pop_front());
            pending_entries.push_back(random_entry(new_key));
        end
        entry_total = pending_entries.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (n_accepted == entry_total);
        wait (n_checked == entry_total);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
